// ===== sv/linear_scan_register_assigner_core_defines.svh =====
// ----------------------------------------------------------------------------
// linear scan register assigner assertion macros
// shared property wrappers on aclk with synchronous reset disable
// ----------------------------------------------------------------------------
`ifndef LINEAR_SCAN_REGISTER_ASSIGNER_CORE_DEFINES_SVH
`define LINEAR_SCAN_REGISTER_ASSIGNER_CORE_DEFINES_SVH

`define LSRA_ASSERT_HOLDS(lbl, expr) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error("lsra assertion failed");

`define LSRA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("lsra assertion failed");

`endif

// ===== sv/lsra_pkg.sv =====
// ----------------------------------------------------------------------------
// lsra_pkg
// types and constants shared by the linear scan register assigner
// ----------------------------------------------------------------------------
package lsra_pkg;

    localparam int SLOTS    = 64;
    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int CNT_W    = $clog2(SLOTS + 1);
    localparam int POOL_MAX = 32;
    localparam int REG_W    = $clog2(POOL_MAX);
    localparam int SIZE_W   = 6;
    localparam int POS_BITS = 16;
    localparam int ID_BITS  = 12;
    localparam int DEPTH_W  = 4;
    localparam int PEAK_W   = 7;

    localparam logic [0:0] CFG_INT_POOL   = 1'b0;
    localparam logic [0:0] CFG_FLOAT_POOL = 1'b1;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    typedef struct packed {
        logic [POS_BITS-1:0] end_pos;
        logic [DEPTH_W-1:0]  depth;
        logic                is_float;
        logic [REG_W-1:0]    reg_idx;
        logic [ID_BITS-1:0]  id;
        logic                is_object;
    } entry_t;

    typedef struct packed {
        logic             found;
        logic [REG_W-1:0] idx;
    } free_t;

endpackage

// ===== sv/lsra_free_find.sv =====
// ----------------------------------------------------------------------------
// lsra_free_find
// lowest clear bit of a busy mask below the pool size
// ----------------------------------------------------------------------------
module lsra_free_find (
    input  logic [lsra_pkg::POOL_MAX-1:0] busy_mask,
    input  logic [lsra_pkg::SIZE_W-1:0]   pool_size,
    output lsra_pkg::free_t               result
);

    always_comb begin
        result = '0;
        for (int r = lsra_pkg::POOL_MAX - 1; r >= 0; r--) begin
            if ((lsra_pkg::SIZE_W'(r) < pool_size) && !busy_mask[r]) begin
                result.found = 1'b1;
                result.idx   = lsra_pkg::REG_W'(r);
            end
        end
    end

endmodule

// ===== sv/linear_scan_register_assigner_core.sv =====
// an allocation request scans the active pieces, one slot per cycle, expiring ended ones
// an eviction compacts the kept pieces from the victim's slot onward, then decides again
// a clear request empties the table and goes straight to the result
// a new request is accepted only once the previous result has been registered for output
// reset: synchronous active low, empties the table, masks and peak,
// pool sizes return to 16
// ----------------------------------------------------------------------------
// linear_scan_register_assigner_core
// linear scan register assignment over a compacting table of active pieces
// ----------------------------------------------------------------------------
`include "linear_scan_register_assigner_core_defines.svh"

module linear_scan_register_assigner_core (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [11:0] s_piece_id,
    input  logic [15:0] s_start_pos,
    input  logic [15:0] s_end_pos,
    input  logic [3:0]  s_loop_depth,
    input  logic        s_float_class,
    input  logic        s_object_class,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_got_register,
    output logic [4:0]  m_assigned_reg,
    output logic        m_self_spilled,
    output logic        m_victim_valid,
    output logic [11:0] m_victim_id,
    output logic        m_object_spill,
    output logic [5:0]  m_peak_pressure
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXPIRE = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_EVICT  = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    localparam int CW = lsra_pkg::CNT_W;
    localparam int SW = lsra_pkg::SIZE_W;

    logic [2:0]    state_reg, state_next;
    logic [SW-1:0] int_size_reg, float_size_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] rd_reg, rd_next;
    logic [CW-1:0] wr_reg, wr_next;
    logic          dv_reg, dv_next;
    logic [31:0]   int_mask_reg, int_mask_next;
    logic [31:0]   float_mask_reg, float_mask_next;
    logic [lsra_pkg::PEAK_W-1:0] peak_reg, peak_next;

    logic [15:0]   start_reg;
    logic [15:0]   end_reg;
    logic [3:0]    depth_reg;
    logic [11:0]   id_reg;
    logic          isf_reg;
    logic          obj_reg;

    logic                   have_reg, have_next;
    logic [CW-1:0]          vslot_reg, vslot_next;
    lsra_pkg::entry_t       vent_reg, vent_next;
    logic                   evicted_reg, evicted_next;

    logic          r_got_reg, r_got_next;
    logic [4:0]    r_reg_reg, r_reg_next;
    logic          r_self_reg, r_self_next;
    logic          r_vv_reg, r_vv_next;
    logic [11:0]   r_vid_reg, r_vid_next;
    logic          r_os_reg, r_os_next;

    logic          mv_reg, mv_next;
    logic          mo_got_reg;
    logic [4:0]    mo_reg_reg;
    logic          mo_self_reg;
    logic          mo_vv_reg;
    logic [11:0]   mo_vid_reg;
    logic          mo_os_reg;
    logic [5:0]    mo_peak_reg;

    lsra_pkg::entry_t mem [lsra_pkg::SLOTS];
    lsra_pkg::entry_t rdata_reg;
    logic                             re;
    logic [lsra_pkg::SLOT_W-1:0]      raddr;
    logic                             we;
    logic [lsra_pkg::SLOT_W-1:0]      waddr;
    lsra_pkg::entry_t                 wdata;

    logic [SW-1:0] ipool, fpool, psize, maxpool;
    logic [31:0]   pmask;
    lsra_pkg::free_t free_res;
    logic          accept;
    logic          s_isf;
    logic          better;
    logic          evict_ok;
    logic [lsra_pkg::PEAK_W-1:0] peak_clamp;

    assign ipool   = (int_size_reg > SW'(lsra_pkg::POOL_MAX)) ?
                     SW'(lsra_pkg::POOL_MAX) : int_size_reg;
    assign fpool   = (float_size_reg > SW'(lsra_pkg::POOL_MAX)) ?
                     SW'(lsra_pkg::POOL_MAX) : float_size_reg;
    assign maxpool = (ipool > fpool) ? ipool : fpool;
    assign psize   = isf_reg ? fpool : ipool;
    assign pmask   = isf_reg ? float_mask_reg : int_mask_reg;
    assign s_isf   = s_float_class && (fpool != '0);

    lsra_free_find u_free (
        .busy_mask (pmask),
        .pool_size (psize),
        .result    (free_res)
    );

    // apb
    assign pready = 1'b1;
    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            lsra_pkg::CFG_INT_POOL:   prdata[SW-1:0] = int_size_reg;
            lsra_pkg::CFG_FLOAT_POOL: prdata[SW-1:0] = float_size_reg;
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            int_size_reg   <= SW'(16);
            float_size_reg <= SW'(16);
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[2])
                lsra_pkg::CFG_INT_POOL:   int_size_reg   <= pwdata[SW-1:0];
                lsra_pkg::CFG_FLOAT_POOL: float_size_reg <= pwdata[SW-1:0];
                default: ;
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    assign better = !have_reg || (rdata_reg.depth < vent_reg.depth) ||
                    ((rdata_reg.depth == vent_reg.depth) &&
                     (rdata_reg.end_pos > vent_reg.end_pos));
    assign evict_ok = have_reg && !evicted_reg &&
                      ((vent_reg.depth < depth_reg) ||
                       ((vent_reg.depth == depth_reg) && (vent_reg.end_pos > end_reg)));
    assign peak_clamp = (peak_reg < lsra_pkg::PEAK_W'(maxpool)) ?
                        peak_reg : lsra_pkg::PEAK_W'(maxpool);

    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        rd_next         = rd_reg;
        wr_next         = wr_reg;
        dv_next         = 1'b0;
        int_mask_next   = int_mask_reg;
        float_mask_next = float_mask_reg;
        peak_next       = peak_reg;
        have_next       = have_reg;
        vslot_next      = vslot_reg;
        vent_next       = vent_reg;
        evicted_next    = evicted_reg;
        r_got_next      = r_got_reg;
        r_reg_next      = r_reg_reg;
        r_self_next     = r_self_reg;
        r_vv_next       = r_vv_reg;
        r_vid_next      = r_vid_reg;
        r_os_next       = r_os_reg;
        mv_next         = mv_reg;
        re              = 1'b0;
        raddr           = rd_reg[lsra_pkg::SLOT_W-1:0];
        we              = 1'b0;
        waddr           = wr_reg[lsra_pkg::SLOT_W-1:0];
        wdata           = rdata_reg;

        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    r_got_next   = 1'b0;
                    r_reg_next   = '0;
                    r_self_next  = 1'b0;
                    r_vv_next    = 1'b0;
                    r_vid_next   = '0;
                    r_os_next    = 1'b0;
                    have_next    = 1'b0;
                    evicted_next = 1'b0;
                    rd_next      = '0;
                    wr_next      = '0;
                    if (s_kind == lsra_pkg::KIND_CLEAR) begin
                        cnt_next        = '0;
                        int_mask_next   = '0;
                        float_mask_next = '0;
                        peak_next       = '0;
                        state_next      = ST_DONE;
                    end else begin
                        state_next = ST_EXPIRE;
                    end
                end
            end
            ST_EXPIRE: begin
                if (rd_reg < cnt_reg) begin
                    re      = 1'b1;
                    rd_next = rd_reg + 1'b1;
                    dv_next = 1'b1;
                end
                if (dv_reg) begin
                    if (rdata_reg.end_pos < start_reg) begin
                        if (rdata_reg.is_float) begin
                            float_mask_next[rdata_reg.reg_idx] = 1'b0;
                        end else begin
                            int_mask_next[rdata_reg.reg_idx] = 1'b0;
                        end
                    end else begin
                        we      = 1'b1;
                        wr_next = wr_reg + 1'b1;
                        if ((rdata_reg.is_float == isf_reg) && better) begin
                            have_next  = 1'b1;
                            vslot_next = wr_reg;
                            vent_next  = rdata_reg;
                        end
                    end
                end else if (rd_reg >= cnt_reg) begin
                    cnt_next = wr_reg;
                    if (lsra_pkg::PEAK_W'(wr_reg) > peak_reg) begin
                        peak_next = lsra_pkg::PEAK_W'(wr_reg);
                    end
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                priority if (free_res.found && (cnt_reg < CW'(lsra_pkg::SLOTS))) begin
                    we    = 1'b1;
                    waddr = cnt_reg[lsra_pkg::SLOT_W-1:0];
                    wdata = '{end_pos: end_reg, depth: depth_reg, is_float: isf_reg,
                              reg_idx: free_res.idx, id: id_reg, is_object: obj_reg};
                    if (isf_reg) begin
                        float_mask_next[free_res.idx] = 1'b1;
                    end else begin
                        int_mask_next[free_res.idx] = 1'b1;
                    end
                    cnt_next   = cnt_reg + 1'b1;
                    r_got_next = 1'b1;
                    r_reg_next = free_res.idx;
                    state_next = ST_DONE;
                end else if (!free_res.found && evict_ok) begin
                    if (isf_reg) begin
                        float_mask_next[vent_reg.reg_idx] = 1'b0;
                    end else begin
                        int_mask_next[vent_reg.reg_idx] = 1'b0;
                    end
                    evicted_next = 1'b1;
                    r_vv_next    = 1'b1;
                    r_vid_next   = vent_reg.id;
                    r_os_next    = !isf_reg && vent_reg.is_object;
                    rd_next      = vslot_reg + 1'b1;
                    wr_next      = vslot_reg;
                    state_next   = ST_EVICT;
                end else begin
                    r_self_next = 1'b1;
                    r_os_next   = r_os_reg || (!isf_reg && obj_reg);
                    state_next  = ST_DONE;
                end
            end
            ST_EVICT: begin
                if (rd_reg < cnt_reg) begin
                    re      = 1'b1;
                    rd_next = rd_reg + 1'b1;
                    dv_next = 1'b1;
                end
                if (dv_reg) begin
                    we      = 1'b1;
                    wr_next = wr_reg + 1'b1;
                end else if (rd_reg >= cnt_reg) begin
                    cnt_next   = wr_reg;
                    state_next = ST_DECIDE;
                end
            end
            ST_DONE: begin
                if (!mv_reg || m_ready) begin
                    mv_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            rd_reg         <= '0;
            wr_reg         <= '0;
            dv_reg         <= 1'b0;
            int_mask_reg   <= '0;
            float_mask_reg <= '0;
            peak_reg       <= '0;
            have_reg       <= 1'b0;
            evicted_reg    <= 1'b0;
            mv_reg         <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            rd_reg         <= rd_next;
            wr_reg         <= wr_next;
            dv_reg         <= dv_next;
            int_mask_reg   <= int_mask_next;
            float_mask_reg <= float_mask_next;
            peak_reg       <= peak_next;
            have_reg       <= have_next;
            evicted_reg    <= evicted_next;
            mv_reg         <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        vslot_reg  <= vslot_next;
        vent_reg   <= vent_next;
        r_got_reg  <= r_got_next;
        r_reg_reg  <= r_reg_next;
        r_self_reg <= r_self_next;
        r_vv_reg   <= r_vv_next;
        r_vid_reg  <= r_vid_next;
        r_os_reg   <= r_os_next;
        if (accept) begin
            start_reg <= s_start_pos;
            end_reg   <= s_end_pos;
            depth_reg <= s_loop_depth;
            id_reg    <= s_piece_id;
            isf_reg   <= s_isf;
            obj_reg   <= s_object_class;
        end
        if ((state_reg == ST_DONE) && (!mv_reg || m_ready)) begin
            mo_got_reg  <= r_got_reg;
            mo_reg_reg  <= r_reg_reg;
            mo_self_reg <= r_self_reg;
            mo_vv_reg   <= r_vv_reg;
            mo_vid_reg  <= r_vid_reg;
            mo_os_reg   <= r_os_reg;
            mo_peak_reg <= peak_clamp[SW-1:0];
        end
    end

    // active table
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign m_valid         = mv_reg;
    assign m_got_register  = mo_got_reg;
    assign m_assigned_reg  = mo_reg_reg;
    assign m_self_spilled  = mo_self_reg;
    assign m_victim_valid  = mo_vv_reg;
    assign m_victim_id     = mo_vid_reg;
    assign m_object_spill  = mo_os_reg;
    assign m_peak_pressure = mo_peak_reg;

    `LSRA_ASSERT_HOLDS(a_cnt_bound, cnt_reg <= CW'(lsra_pkg::SLOTS))
    `LSRA_ASSERT_HOLDS(a_got_xor_self, !(mv_reg && mo_got_reg && mo_self_reg))
    `LSRA_ASSERT_HOLDS(a_victim_ends, !(mv_reg && mo_vv_reg) || mo_got_reg || mo_self_reg)
    `LSRA_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready)

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// checks the linear scan register assigner against an in-bench allocator:
// directed corner cases, pool size sweeps and mostly sorted random piece streams,
// with random idling on both sides and a long result stall
// ----------------------------------------------------------------------------
module tb;

    typedef struct packed {
        logic        got;
        logic [4:0]  rg;
        logic        self_sp;
        logic        vvalid;
        logic [11:0] vid;
        logic        ospill;
        logic [5:0]  peak;
    } alloc_res_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_kind = 1'b0;
    logic [11:0] s_piece_id = '0;
    logic [15:0] s_start_pos = '0, s_end_pos = '0;
    logic [3:0]  s_loop_depth = '0;
    logic        s_float_class = 1'b0, s_object_class = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_got_register;
    logic [4:0]  m_assigned_reg;
    logic        m_self_spilled, m_victim_valid;
    logic [11:0] m_victim_id;
    logic        m_object_spill;
    logic [5:0]  m_peak_pressure;

    linear_scan_register_assigner_core dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // allocator state
    int unsigned   int_size, flt_size;
    int unsigned   act_n;
    logic [15:0]   a_end [lsra_pkg::SLOTS];
    logic [3:0]    a_depth [lsra_pkg::SLOTS];
    logic          a_flt [lsra_pkg::SLOTS];
    logic [4:0]    a_reg [lsra_pkg::SLOTS];
    logic [11:0]   a_id [lsra_pkg::SLOTS];
    logic          a_obj [lsra_pkg::SLOTS];
    logic [31:0]   int_busy, flt_busy;
    int unsigned   peak_seen;

    alloc_res_t    pending_q[$];
    int            err_count = 0;
    int            req_count = 0, evict_count = 0, spill_count = 0;
    logic          idle_on = 1'b1;
    logic          hold_sink = 1'b0;
    logic [15:0]   cur_pos = 0;

    function automatic int unsigned clamp_pool(int unsigned v);
        return v > lsra_pkg::POOL_MAX ? lsra_pkg::POOL_MAX : v;
    endfunction

    function automatic void clear_table();
        act_n = 0;
        int_busy = '0;
        flt_busy = '0;
        peak_seen = 0;
    endfunction

    function automatic void drop_entry(int unsigned k);
        if (a_flt[k]) flt_busy[a_reg[k]] = 1'b0;
        else int_busy[a_reg[k]] = 1'b0;
        for (int unsigned i = k; i + 1 < act_n; i++) begin
            a_end[i] = a_end[i+1];
            a_depth[i] = a_depth[i+1];
            a_flt[i] = a_flt[i+1];
            a_reg[i] = a_reg[i+1];
            a_id[i] = a_id[i+1];
            a_obj[i] = a_obj[i+1];
        end
        act_n--;
    endfunction

    function automatic int lowest_free(logic [31:0] m, int unsigned sz);
        for (int r = 0; r < sz; r++)
            if (!m[r]) return r;
        return -1;
    endfunction

    function automatic alloc_res_t assign_piece(logic kind, logic [11:0] id,
            logic [15:0] st, logic [15:0] en, logic [3:0] dp, logic fc, logic oc);
        alloc_res_t  r;
        int unsigned ip, fp, psz, k, v, mx;
        logic        is_f, have;
        int          rg;
        r = '0;
        ip = clamp_pool(int_size);
        fp = clamp_pool(flt_size);
        if (kind == lsra_pkg::KIND_CLEAR) begin
            clear_table();
            return r;
        end
        is_f = fc && fp > 0;
        k = 0;
        while (k < act_n) begin
            if (a_end[k] < st) drop_entry(k);
            else k++;
        end
        if (act_n > peak_seen) peak_seen = act_n;
        psz = is_f ? fp : ip;
        rg = lowest_free(is_f ? flt_busy : int_busy, psz);
        if (rg < 0) begin
            have = 1'b0;
            v = 0;
            for (k = 0; k < act_n; k++) begin
                if (a_flt[k] != is_f) continue;
                if (!have) begin
                    have = 1'b1;
                    v = k;
                end else if (a_depth[k] < a_depth[v]) begin
                    v = k;
                end else if (a_depth[k] == a_depth[v] && a_end[k] > a_end[v]) begin
                    v = k;
                end
            end
            if (have && (a_depth[v] < dp || (a_depth[v] == dp && a_end[v] > en))) begin
                r.vvalid = 1'b1;
                r.vid = a_id[v];
                if (!a_flt[v] && a_obj[v]) r.ospill = 1'b1;
                drop_entry(v);
                rg = lowest_free(is_f ? flt_busy : int_busy, psz);
            end
        end
        if (rg >= 0 && act_n < lsra_pkg::SLOTS) begin
            if (is_f) flt_busy[rg] = 1'b1;
            else int_busy[rg] = 1'b1;
            a_end[act_n] = en;
            a_depth[act_n] = dp;
            a_flt[act_n] = is_f;
            a_reg[act_n] = rg[4:0];
            a_id[act_n] = id;
            a_obj[act_n] = oc;
            act_n++;
            r.got = 1'b1;
            r.rg = rg[4:0];
        end else begin
            r.self_sp = 1'b1;
            if (!is_f && oc) r.ospill = 1'b1;
        end
        mx = ip > fp ? ip : fp;
        r.peak = 6'(peak_seen < mx ? peak_seen : mx);
        return r;
    endfunction

    task automatic report_mismatch(string what, int got_v, int exp_v);
        $display("mismatch %s: got %0d expected %0d", what, got_v, exp_v);
        err_count++;
    endtask

    // result checker
    always @(posedge aclk) begin
        alloc_res_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_q.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                e = pending_q.pop_front();
                if (m_got_register !== e.got) report_mismatch("got_register", m_got_register, e.got);
                if (m_assigned_reg !== e.rg) report_mismatch("assigned_reg", m_assigned_reg, e.rg);
                if (m_self_spilled !== e.self_sp)
                    report_mismatch("self_spilled", m_self_spilled, e.self_sp);
                if (m_victim_valid !== e.vvalid)
                    report_mismatch("victim_valid", m_victim_valid, e.vvalid);
                if (m_victim_id !== e.vid) report_mismatch("victim_id", m_victim_id, e.vid);
                if (m_object_spill !== e.ospill)
                    report_mismatch("object_spill", m_object_spill, e.ospill);
                if (m_peak_pressure !== e.peak)
                    report_mismatch("peak_pressure", m_peak_pressure, e.peak);
                if (e.vvalid) evict_count++;
                if (e.self_sp) spill_count++;
            end
        end
    end

    // result side ready
    always @(negedge aclk) begin
        if (hold_sink) m_ready <= 1'b0;
        else m_ready <= !(idle_on && $urandom_range(99) < 12);
    end

    task automatic send_request(logic kind, logic [11:0] id, logic [15:0] st,
            logic [15:0] en, logic [3:0] dp, logic fc, logic oc);
        @(negedge aclk);
        while (idle_on && $urandom_range(99) < 12) @(negedge aclk);
        s_valid <= 1'b1;
        s_kind <= kind;
        s_piece_id <= id;
        s_start_pos <= st;
        s_end_pos <= en;
        s_loop_depth <= dp;
        s_float_class <= fc;
        s_object_class <= oc;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_q.insert(pending_q.size(), assign_piece(kind, id, st, en, dp, fc, oc));
        req_count++;
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic send_piece(logic [15:0] st, logic [15:0] en, logic [3:0] dp,
            logic fc, logic oc);
        send_request(lsra_pkg::KIND_ALLOC, 12'($urandom), st, en, dp, fc, oc);
    endtask

    task automatic drain();
        while (pending_q.size() != 0) @(posedge aclk);
        // allow the last request to retire fully
        repeat (300) @(negedge aclk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [5:0] val);
        @(negedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {$urandom} & 32'hffff_ffc0 | val;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (idx == lsra_pkg::CFG_INT_POOL) int_size = val;
        else flt_size = val;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic test_directed();
        send_piece(16'h0000, 16'hffff, 4'hf, 1'b0, 1'b1);
        send_piece(16'h0000, 16'h0000, 4'h0, 1'b1, 1'b0);
        send_request(lsra_pkg::KIND_ALLOC, 12'hfff, 16'h0001, 16'h0000, 4'h7, 1'b0, 1'b1);
        send_piece(16'h0002, 16'h0010, 4'h3, 1'b1, 1'b1);
        send_request(lsra_pkg::KIND_CLEAR, 12'hfff, 16'hffff, 16'hffff, 4'hf, 1'b1, 1'b1);
        send_piece(16'hffff, 16'hffff, 4'h0, 1'b0, 1'b0);
        send_request(lsra_pkg::KIND_CLEAR, '0, '0, '0, '0, 1'b0, 1'b0);
        drain();
        // tiny pools: eviction, self spill, float falling to integer
        write_reg(lsra_pkg::CFG_INT_POOL, 6'd1);
        write_reg(lsra_pkg::CFG_FLOAT_POOL, 6'd0);
        send_piece(16'd10, 16'd100, 4'd2, 1'b0, 1'b1);
        send_piece(16'd11, 16'd90, 4'd5, 1'b1, 1'b0);
        send_piece(16'd12, 16'd95, 4'd5, 1'b0, 1'b1);
        send_piece(16'd13, 16'd80, 4'd5, 1'b0, 1'b1);
        send_piece(16'd200, 16'd300, 4'd0, 1'b1, 1'b1);
        send_request(lsra_pkg::KIND_CLEAR, '0, '0, '0, '0, 1'b0, 1'b0);
        drain();
        // zero integer pool: every integer piece spills
        write_reg(lsra_pkg::CFG_INT_POOL, 6'd0);
        write_reg(lsra_pkg::CFG_FLOAT_POOL, 6'd63);
        send_piece(16'd1, 16'd5, 4'd9, 1'b0, 1'b1);
        send_piece(16'd2, 16'd5, 4'd9, 1'b1, 1'b1);
        drain();
        // shrink pool while pieces are active
        write_reg(lsra_pkg::CFG_FLOAT_POOL, 6'd1);
        send_piece(16'd3, 16'd9, 4'd1, 1'b1, 1'b0);
        send_piece(16'd10, 16'd20, 4'd1, 1'b1, 1'b0);
        send_request(lsra_pkg::KIND_CLEAR, '0, '0, '0, '0, 1'b0, 1'b0);
        drain();
    endtask

    task automatic random_stream(int count, int max_len);
        int unsigned p;
        for (int i = 0; i < count; i++) begin
            p = $urandom_range(99);
            if (p < 2) begin
                send_request(lsra_pkg::KIND_CLEAR, 12'($urandom), 16'($urandom),
                             16'($urandom), 4'($urandom), 1'($urandom), 1'($urandom));
                cur_pos = 16'($urandom_range(0, 300));
            end else if (p < 5) begin
                // out of order start, noise
                send_piece(16'($urandom), 16'($urandom), 4'($urandom), 1'($urandom),
                           1'($urandom));
            end else begin
                if (cur_pos > 16'hff00) cur_pos = 16'($urandom_range(0, 50));
                cur_pos = cur_pos + 16'($urandom_range(0, 3));
                send_piece(cur_pos, (p < 8) ? 16'($urandom_range(0, cur_pos))
                           : 16'(cur_pos + $urandom_range(0, max_len)),
                           4'($urandom), 1'($urandom), 1'($urandom));
            end
        end
    endtask

    task automatic test_random_sweep();
        logic [5:0] sizes [6] = '{6'd63, 6'd32, 6'd2, 6'd16, 6'd33, 6'd5};
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(lsra_pkg::CFG_INT_POOL, sizes[ph]);
            write_reg(lsra_pkg::CFG_FLOAT_POOL, sizes[(ph + 3) % 6]);
            idle_on = (ph != 2);
            random_stream(180, (ph % 2) ? 40 : 400);
            send_request(lsra_pkg::KIND_CLEAR, '0, '0, '0, '0, 1'b0, 1'b0);
            drain();
        end
        idle_on = 1'b1;
    endtask

    task automatic test_backpressure();
        write_reg(lsra_pkg::CFG_INT_POOL, 6'd32);
        write_reg(lsra_pkg::CFG_FLOAT_POOL, 6'd32);
        fork
            begin
                hold_sink = 1'b1;
                repeat (600) @(negedge aclk);
                hold_sink = 1'b0;
            end
            random_stream(80, 2000);
        join
        // full active table: long lives in both pools
        for (int i = 0; i < 70; i++)
            send_piece(16'(1000 + i), 16'hfff0, 4'($urandom), 1'(i % 2), 1'($urandom));
        drain();
    endtask

    initial begin
        clear_table();
        int_size = 16;
        flt_size = 16;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_random_sweep();
        test_backpressure();
        $display("%0d requests sent, %0d evictions and %0d spills checked",
                 req_count, evict_count, spill_count);
        $display("pool sizes swept from 0 to 63, clears and stalls included");
        if (err_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("tb: errors");
        $finish;
    end
endmodule
